[rtl/core/bzcd_pkg.sv]
// shared types and constants for the back-emf zero-cross detector
// no dependencies; imported by bemf_zero_cross_detector
`default_nettype none

package bzcd_pkg;

  localparam int TIME_BITS = 24;

  typedef logic [TIME_BITS-1:0] stamp_t;
  typedef logic [1:0]           func_t;
  typedef logic [2:0]           cfg_idx_t;

  // item kinds
  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_PHASE = 2'd1;
  localparam func_t FUNC_EDGE  = 2'd2;

  // register indexes
  localparam cfg_idx_t REG_MIN_PHASE_GAP  = 3'd0;
  localparam cfg_idx_t REG_MAX_PHASE_GAP  = 3'd1;
  localparam cfg_idx_t REG_BLANKING_TICKS = 3'd2;
  localparam cfg_idx_t REG_FILTER_TICKS   = 3'd3;
  localparam cfg_idx_t REG_ADVANCE_DEBT   = 3'd4;
  localparam cfg_idx_t REG_FALLBACK_DELAY = 3'd5;

  // register reset values
  localparam stamp_t MIN_PHASE_GAP_RST  = 24'd0;
  localparam stamp_t MAX_PHASE_GAP_RST  = 24'hFFFFFF;
  localparam stamp_t BLANKING_TICKS_RST = 24'd100;
  localparam stamp_t FILTER_TICKS_RST   = 24'd20;
  localparam stamp_t ADVANCE_DEBT_RST   = 24'd0;
  localparam stamp_t FALLBACK_DELAY_RST = 24'd1;

  typedef struct packed {
    func_t func;
    logic  edge_match;
    logic  detecting;
    logic  locked;
  } item_t;

  typedef struct packed {
    logic   zero_cross_found;
    logic   commutation_set;
    stamp_t commutation_time;
    stamp_t period;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/bemf_zero_cross_detector.sv]
// back-emf zero-cross qualifier: time base, blanking/filter sequencing, gap check,
// period averaging and commutation scheduling; depends on bzcd_pkg
// an accepted item passes the control, average, delay and result registers in turn;
// one item per cycle while result_stall is low; the four-register pipeline (control,
// average, delay, result) moves whenever the stage ahead is empty or moving
// reset: synchronous, clears all timing state and pipeline valids and loads the
// register defaults; no memory, so no clearing pass
`default_nettype none

module bemf_zero_cross_detector (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_stall,
  input  bzcd_pkg::item_t      item,
  output logic                 result_valid,
  input  wire                  result_stall,
  output bzcd_pkg::result_t    result,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  bzcd_pkg::cfg_idx_t   cfg_index,
  input  bzcd_pkg::stamp_t     cfg_data
);
  import bzcd_pkg::*;

  typedef struct packed {
    logic   found;
    logic   sched;
    stamp_t gap;
    stamp_t now;
  } stg_a_t;

  typedef struct packed {
    logic   found;
    logic   sched;
    stamp_t now;
    stamp_t period;
  } stg_b_t;

  typedef struct packed {
    logic   found;
    logic   sched;
    stamp_t now;
    stamp_t period;
    stamp_t delay;
  } stg_c_t;

  // configuration
  stamp_t min_phase_gap, max_phase_gap, blanking_ticks;
  stamp_t filter_ticks, advance_debt, fallback_delay;

  // control state
  stamp_t time_count, time_inc, gap_count, gap_inc, deadline;
  logic   deadline_armed, filter_mode, comparator_enabled;
  stamp_t time_count_next, time_inc_next, gap_count_next, gap_inc_next, deadline_next;
  logic   deadline_armed_next, filter_mode_next, comparator_enabled_next;

  // scheduling state
  stamp_t avg_period, next_commutation;

  // pipeline
  stg_a_t stg_a, stg_a_next;
  stg_b_t stg_b, stg_b_next;
  stg_c_t stg_c, stg_c_next;
  result_t result_next;
  logic   a_valid, b_valid, c_valid;
  logic   rdy_out, rdy_c, rdy_b, rdy_a;
  logic   item_acc;

  logic               fire, gap_ok;
  logic [TIME_BITS:0] avg_sum;
  stamp_t             avg_new, half, nc_new;

  assign cfg_ready = 1'b1;

  assign rdy_out    = !result_valid || !result_stall;
  assign rdy_c      = !c_valid || rdy_out;
  assign rdy_b      = !b_valid || rdy_c;
  assign rdy_a      = !a_valid || rdy_b;
  assign item_stall = !rdy_a;
  assign item_acc   = item_valid && rdy_a;

  // control stage
  assign fire   = deadline_armed && (time_inc == deadline);
  assign gap_ok = (gap_inc > min_phase_gap) && (gap_inc < max_phase_gap);

  always_comb begin
    time_count_next         = time_count;
    time_inc_next           = time_inc;
    gap_count_next          = gap_count;
    gap_inc_next            = gap_inc;
    deadline_next           = deadline;
    deadline_armed_next     = deadline_armed;
    filter_mode_next        = filter_mode;
    comparator_enabled_next = comparator_enabled;
    stg_a_next.found        = 1'b0;
    stg_a_next.sched        = 1'b0;
    stg_a_next.gap          = gap_inc;
    stg_a_next.now          = time_inc;
    if (item_acc) begin
      case (item.func)
        FUNC_TICK: begin
          time_count_next = time_inc;
          time_inc_next   = time_inc + 1'b1;
          gap_count_next  = gap_inc;
          gap_inc_next    = gap_inc + 1'b1;
          if (fire) begin
            if (!filter_mode) begin
              deadline_armed_next     = 1'b0;
              filter_mode_next        = 1'b1;
              comparator_enabled_next = 1'b1;
            end else if (item.edge_match && gap_ok) begin
              stg_a_next.found        = 1'b1;
              stg_a_next.sched        = item.locked;
              comparator_enabled_next = 1'b0;
              deadline_armed_next     = 1'b0;
              gap_count_next          = '0;
              gap_inc_next            = stamp_t'(1);
            end
          end
        end
        FUNC_PHASE: begin
          if (item.detecting) begin
            deadline_next       = time_count + blanking_ticks;
            filter_mode_next    = 1'b0;
            deadline_armed_next = 1'b1;
          end
        end
        FUNC_EDGE: begin
          if (comparator_enabled && filter_mode) begin
            deadline_next       = time_count + filter_ticks;
            deadline_armed_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // averaging stage
  assign avg_sum = {1'b0, stg_a.gap} + {1'b0, avg_period};
  assign avg_new = avg_sum[TIME_BITS:1];

  always_comb begin
    stg_b_next.found  = stg_a.found;
    stg_b_next.sched  = stg_a.sched;
    stg_b_next.now    = stg_a.now;
    stg_b_next.period = stg_a.sched ? avg_new : avg_period;
  end

  // delay stage
  assign half = stg_b.period >> 1;

  always_comb begin
    stg_c_next.found  = stg_b.found;
    stg_c_next.sched  = stg_b.sched;
    stg_c_next.now    = stg_b.now;
    stg_c_next.period = stg_b.period;
    stg_c_next.delay  = (half > advance_debt) ? (half - advance_debt) : fallback_delay;
  end

  // scheduling stage
  assign nc_new = stg_c.now + stg_c.delay;

  always_comb begin
    result_next.zero_cross_found = stg_c.found;
    result_next.commutation_set  = stg_c.sched;
    result_next.commutation_time = stg_c.sched ? nc_new : next_commutation;
    result_next.period           = stg_c.period;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_phase_gap      <= MIN_PHASE_GAP_RST;
      max_phase_gap      <= MAX_PHASE_GAP_RST;
      blanking_ticks     <= BLANKING_TICKS_RST;
      filter_ticks       <= FILTER_TICKS_RST;
      advance_debt       <= ADVANCE_DEBT_RST;
      fallback_delay     <= FALLBACK_DELAY_RST;
      time_count         <= '0;
      time_inc           <= stamp_t'(1);
      gap_count          <= '0;
      gap_inc            <= stamp_t'(1);
      deadline           <= '0;
      deadline_armed     <= 1'b0;
      filter_mode        <= 1'b0;
      comparator_enabled <= 1'b0;
      avg_period         <= '0;
      next_commutation   <= '0;
      a_valid            <= 1'b0;
      b_valid            <= 1'b0;
      c_valid            <= 1'b0;
      result_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_PHASE_GAP:  min_phase_gap  <= cfg_data;
          REG_MAX_PHASE_GAP:  max_phase_gap  <= cfg_data;
          REG_BLANKING_TICKS: blanking_ticks <= cfg_data;
          REG_FILTER_TICKS:   filter_ticks   <= cfg_data;
          REG_ADVANCE_DEBT:   advance_debt   <= cfg_data;
          REG_FALLBACK_DELAY: fallback_delay <= cfg_data;
          default: begin
          end
        endcase
      end
      time_count         <= time_count_next;
      time_inc           <= time_inc_next;
      gap_count          <= gap_count_next;
      gap_inc            <= gap_inc_next;
      deadline           <= deadline_next;
      deadline_armed     <= deadline_armed_next;
      filter_mode        <= filter_mode_next;
      comparator_enabled <= comparator_enabled_next;
      if (rdy_a) begin
        a_valid <= item_acc;
      end
      if (rdy_b) begin
        b_valid <= a_valid;
        if (a_valid && stg_a.sched) begin
          avg_period <= avg_new;
        end
      end
      if (rdy_c) begin
        c_valid <= b_valid;
      end
      if (rdy_out) begin
        result_valid <= c_valid;
        if (c_valid && stg_c.sched) begin
          next_commutation <= nc_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      stg_a <= stg_a_next;
    end
    if (rdy_b) begin
      stg_b <= stg_b_next;
    end
    if (rdy_c) begin
      stg_c <= stg_c_next;
    end
    if (rdy_out) begin
      result <= result_next;
    end
  end

  // gap_count mirrors time_count minus the last crossing; only its successor is compared
  a_time_inc: assert property (@(posedge clk) disable iff (rst)
    time_inc == time_count + 1'b1)
    else $error("time base successor out of step");

  a_gap_inc: assert property (@(posedge clk) disable iff (rst)
    gap_inc == gap_count + 1'b1)
    else $error("gap counter successor out of step");

  a_found_disarms: assert property (@(posedge clk) disable iff (rst)
    item_acc && stg_a_next.found |=> !deadline_armed && !comparator_enabled)
    else $error("accepted crossing left comparator or deadline active");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> a_valid && b_valid && c_valid && result_valid && result_stall)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

[tb/tb.sv]
// testbench for bemf_zero_cross_detector: queued driver, stalling monitor and an
// in-line model of the blanking/filter/gap logic that predicts every result item
// depends on bzcd_pkg and bemf_zero_cross_detector
`timescale 1ns / 1ps

module tb;
  import bzcd_pkg::*;

  localparam func_t FUNC_SPARE = 2'd3;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_stall;
  item_t    item = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  result_t  result;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = '0;
  stamp_t   cfg_data = '0;

  bemf_zero_cross_detector uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 600000);
    $display("simulation failed");
    $finish;
  end

  // register copy and detector state as the model sees them
  stamp_t reg_file [0:5] = '{MIN_PHASE_GAP_RST, MAX_PHASE_GAP_RST, BLANKING_TICKS_RST,
                             FILTER_TICKS_RST, ADVANCE_DEBT_RST, FALLBACK_DELAY_RST};
  stamp_t tb_time = '0;
  stamp_t last_zc = '0;
  stamp_t avg_gap = '0;
  stamp_t wake_at = '0;
  stamp_t next_comm = '0;
  bit     wake_armed = 1'b0;
  bit     filtering = 1'b0;
  bit     cmp_on = 1'b0;

  item_t   pending_items[$];
  result_t expected_results[$];

  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned crossings_seen = 0;
  int unsigned schedules_seen = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 0;
  bit          hold_req = 1'b0;

  function automatic result_t bemf_predict(item_t it);
    result_t                r;
    stamp_t                 gap;
    stamp_t                 half;
    stamp_t                 dly;
    logic [TIME_BITS:0]     sum;
    r = '0;
    case (it.func)
      FUNC_TICK: begin
        tb_time = tb_time + 1'b1;
        if (wake_armed && tb_time == wake_at) begin
          if (!filtering) begin
            wake_armed = 1'b0;
            filtering = 1'b1;
            cmp_on = 1'b1;
          end else if (it.edge_match) begin
            gap = tb_time - last_zc;
            if (gap > reg_file[REG_MIN_PHASE_GAP] && gap < reg_file[REG_MAX_PHASE_GAP]) begin
              r.zero_cross_found = 1'b1;
              last_zc = tb_time;
              if (it.locked) begin
                sum = {1'b0, gap} + {1'b0, avg_gap};
                avg_gap = sum[TIME_BITS:1];
                half = avg_gap >> 1;
                if (half > reg_file[REG_ADVANCE_DEBT])
                  dly = half - reg_file[REG_ADVANCE_DEBT];
                else
                  dly = reg_file[REG_FALLBACK_DELAY];
                next_comm = tb_time + dly;
                r.commutation_set = 1'b1;
              end
              cmp_on = 1'b0;
              wake_armed = 1'b0;
            end
          end
        end
      end
      FUNC_PHASE: begin
        if (it.detecting) begin
          wake_at = tb_time + reg_file[REG_BLANKING_TICKS];
          filtering = 1'b0;
          wake_armed = 1'b1;
        end
      end
      FUNC_EDGE: begin
        if (cmp_on && filtering) begin
          wake_at = tb_time + reg_file[REG_FILTER_TICKS];
          wake_armed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.commutation_time = next_comm;
    r.period = avg_gap;
    return r;
  endfunction

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70)
      return 0;
    else if (roll < 92)
      return $urandom_range(1, 3);
    else if (roll < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t mk_item(func_t f, bit m, bit d, bit l);
    item_t it;
    it.func = f;
    it.edge_match = m;
    it.detecting = d;
    it.locked = l;
    return it;
  endfunction

  // one phase: change, blanking ticks with stray edges, edges that restart the filter, expiry tick, trailing ticks
  task automatic push_commutation(int unsigned blank, int unsigned filt);
    int unsigned n_edges;
    int unsigned part;
    pending_items.push_back(mk_item(FUNC_PHASE, chance(50), chance(92), chance(50)));
    for (int i = 0; i < blank; i++) begin
      if (chance(10))
        pending_items.push_back(mk_item(FUNC_EDGE, chance(50), chance(50), chance(50)));
      pending_items.push_back(mk_item(FUNC_TICK, chance(50), chance(50), chance(70)));
    end
    n_edges = $urandom_range(1, 3);
    for (int e = 0; e < n_edges; e++) begin
      pending_items.push_back(mk_item(FUNC_EDGE, chance(50), chance(50), chance(50)));
      part = (e == n_edges - 1) ? filt : $urandom_range(0, filt - 1);
      for (int t = 1; t <= part; t++)
        pending_items.push_back(mk_item(FUNC_TICK, (t == part) ? chance(85) : chance(50),
                                        chance(50), (t == part) ? chance(80) : chance(50)));
    end
    repeat ($urandom_range(0, 4))
      pending_items.push_back(mk_item(FUNC_TICK, chance(50), chance(50), chance(50)));
  endtask

  task automatic write_reg(cfg_idx_t idx, stamp_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_file[idx] = val;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  // driver
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!(item_valid && item_stall)) begin
      if (item_valid) begin
        expected_results.push_back(bemf_predict(item));
        void'(pending_items.pop_front());
        items_accepted++;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = idle_len();
          if ($urandom_range(0, 49) == 0)
            send_calm = $urandom_range(30, 120);
        end
      end
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item <= pending_items[0];
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // monitor
  int unsigned stall_left = 0;
  int unsigned recv_calm = 0;
  bit          hold_done = 1'b0;
  result_t     want;

  always @(posedge clk) begin
    if (result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: found=%0b set=%0b comm=%h period=%h",
                   result.zero_cross_found, result.commutation_set,
                   result.commutation_time, result.period);
      end else begin
        want = expected_results.pop_front();
        if (result.zero_cross_found !== want.zero_cross_found ||
            result.commutation_set !== want.commutation_set ||
            result.commutation_time !== want.commutation_time ||
            result.period !== want.period) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("result %0d: expected found=%0b set=%0b comm=%h period=%h, ",
                   results_checked, want.zero_cross_found, want.commutation_set,
                   want.commutation_time, want.period);
            $display("got found=%0b set=%0b comm=%h period=%h",
                     result.zero_cross_found, result.commutation_set,
                     result.commutation_time, result.period);
          end
        end
        results_checked++;
        crossings_seen += want.zero_cross_found;
        schedules_seen += want.commutation_set;
      end
    end
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_left = 300;
      end
      if (stall_left == 0) begin
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          stall_left = idle_len();
          if ($urandom_range(0, 49) == 0)
            recv_calm = $urandom_range(30, 120);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned blank_len;
    int unsigned filt_len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: ignored events, unmatched expiry, locked and unlocked crossings,
    // phase change with comparator still enabled
    write_reg(REG_BLANKING_TICKS, 24'd2);
    write_reg(REG_FILTER_TICKS, 24'd1);
    settings_used++;
    @(negedge clk);
    pending_items.push_back(mk_item(FUNC_TICK, 1'b1, 1'b1, 1'b1));
    pending_items.push_back(mk_item(FUNC_SPARE, 1'b1, 1'b1, 1'b1));
    pending_items.push_back(mk_item(FUNC_EDGE, 1'b1, 1'b1, 1'b1));
    pending_items.push_back(mk_item(FUNC_PHASE, 1'b1, 1'b0, 1'b1));
    pending_items.push_back(mk_item(FUNC_PHASE, 1'b0, 1'b1, 1'b0));
    pending_items.push_back(mk_item(FUNC_EDGE, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_EDGE, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b0, 1'b1, 1'b1));
    pending_items.push_back(mk_item(FUNC_EDGE, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b1, 1'b0, 1'b1));
    pending_items.push_back(mk_item(FUNC_PHASE, 1'b0, 1'b1, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_EDGE, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b1, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_PHASE, 1'b0, 1'b1, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_PHASE, 1'b0, 1'b1, 1'b0));
    pending_items.push_back(mk_item(FUNC_EDGE, 1'b1, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_EDGE, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk_item(FUNC_TICK, 1'b1, 1'b0, 1'b1));
    wait_drained();

    // extremes: empty gap window, blanking that never ends, widest filter
    write_reg(REG_MIN_PHASE_GAP, '1);
    write_reg(REG_MAX_PHASE_GAP, '0);
    write_reg(REG_BLANKING_TICKS, '0);
    write_reg(REG_FILTER_TICKS, '1);
    write_reg(REG_ADVANCE_DEBT, '1);
    write_reg(REG_FALLBACK_DELAY, '1);
    settings_used++;
    @(negedge clk);
    repeat (20)
      pending_items.push_back(mk_item(func_t'($urandom_range(0, 3)), chance(50), chance(50),
                                      chance(50)));
    wait_drained();

    // full window, fallback delay that wraps the schedule
    write_reg(REG_MIN_PHASE_GAP, '0);
    write_reg(REG_MAX_PHASE_GAP, '1);
    write_reg(REG_BLANKING_TICKS, 24'd1);
    write_reg(REG_FILTER_TICKS, 24'd1);
    settings_used++;
    @(negedge clk);
    repeat (5) push_commutation(1, 1);
    wait_drained();

    // zero fallback delay
    write_reg(REG_FALLBACK_DELAY, '0);
    settings_used++;
    @(negedge clk);
    repeat (4) push_commutation(1, 1);
    wait_drained();

    // random settings, mostly well-formed phases with some noise
    for (int p = 0; p < 4; p++) begin
      blank_len = $urandom_range(1, 8);
      filt_len = $urandom_range(1, 6);
      write_reg(REG_MIN_PHASE_GAP, chance(25) ? '0 : stamp_t'($urandom_range(4, 12)));
      write_reg(REG_MAX_PHASE_GAP, chance(25) ? '1 : stamp_t'($urandom_range(14, 30)));
      write_reg(REG_BLANKING_TICKS, stamp_t'(blank_len));
      write_reg(REG_FILTER_TICKS, stamp_t'(filt_len));
      write_reg(REG_ADVANCE_DEBT, stamp_t'($urandom_range(0, 10)));
      write_reg(REG_FALLBACK_DELAY, chance(20) ? stamp_t'($urandom) :
                                                 stamp_t'($urandom_range(0, 40)));
      settings_used++;
      @(negedge clk);
      while (pending_items.size() < 180) begin
        if (chance(15))
          pending_items.push_back(mk_item(func_t'($urandom_range(0, 3)), chance(50),
                                          chance(50), chance(50)));
        else
          push_commutation(blank_len, filt_len);
      end
      if (p == 1)
        hold_req = 1'b1;
      wait_drained();
    end

    $display("%0d items accepted, %0d result items checked over %0d register settings",
             items_accepted, results_checked, settings_used);
    $display("%0d zero crossings accepted, %0d commutations scheduled, %0d mismatches",
             crossings_seen, schedules_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
